/* rtl/kmh_pkg.sv */
`default_nettype none

package kmh_pkg;

  // Default build sizes
  localparam int K_MAX_DEFAULT      = 8;
  localparam int COUNT_BITS_DEFAULT = 16;

  // Fixed field widths of the channels
  localparam int KMER_CODE_W  = 16;
  localparam int KMER_COUNT_W = 16;
  localparam int BASE_W       = 2;
  localparam int KLEN_W       = 4;
  localparam int SEEN_W       = 4;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_KMER_LENGTH = 1'b0;
  localparam logic [KLEN_W-1:0] KMER_LENGTH_RESET = 4'd8;

  // Operation codes
  localparam logic OP_BASE  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Bases seen saturate here
  localparam logic [SEEN_W-1:0] SEEN_MAX = 4'd15;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear_start;  // zero window, bases seen, max and cursor; hold the base
    logic clear_step;   // write zero at the sweep address and advance
    logic base_live;    // shift the incoming base into the window, read its counter
    logic base_held;    // same with the held base, after a clear sweep
    logic update;       // write back the incremented counter, track the max
    logic fetch_start;  // read the counter at the cursor
    logic scan_step;    // evaluate the probed entry, read the next one
    logic emit_miss;    // load an exhausted result without scanning
  } kmh_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic cursor_end;   // cursor is at or past the active table
    logic probe_hit;    // probed counter equals the max
    logic probe_last;   // probed entry is the last of the active table
    logic clear_last;   // sweep is at its last entry
  } kmh_stat_t;

endpackage

`default_nettype wire

/* rtl/kmh_if.sv */
`default_nettype none

// Request channel: bases and fetch requests
interface kmh_req_if import kmh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [BASE_W-1:0] base_code;
  logic              first_base;
  logic              last_base;

  modport source (output valid, operation, base_code, first_base, last_base, input ready);
  modport sink   (input valid, operation, base_code, first_base, last_base, output ready);
endinterface

// Result channel: one most frequent k-mer per fetch
interface kmh_res_if import kmh_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [KMER_CODE_W-1:0]  kmer_code;
  logic [KMER_COUNT_W-1:0] kmer_count;
  logic                    found;

  modport source (output valid, kmer_code, kmer_count, found, input ready);
  modport sink   (input valid, kmer_code, kmer_count, found, output ready);
endinterface

`default_nettype wire

/* rtl/kmer_histogram_most_frequent.sv */
`default_nettype none

// Most frequent k-mer counter.
// req carries one request per handshake: a base (operation 0) or a fetch
// (operation 1). Bases shift into a window of the last k codes; once k bases
// are in, that word's counter in a table of 4^K_MAX saturating counters is
// bumped and the running max tracked. first_base clears table and window
// first; last_base rewinds the fetch cursor. Each fetch returns on res the next
// word, in ascending code order, whose count equals the max, or found=0 once
// the ties are used up. kmer_length is set over the APB port at address 0.
// A base reads its counter, then writes it back on the single memory port
// pair; first_base first runs the clearing sweep of all 4^K_MAX entries, then
// the counter read of the held base. A fetch reads the counter at the cursor,
// then probes one table entry per cycle while the output register is free, or
// loads an exhausted result if the cursor is already past the table; its
// result sits in an output register, and base requests keep flowing while it
// waits. A waiting result holds the next fetch and req.ready low until res is
// taken. After reset all 4^K_MAX entries (65536 at K_MAX=8) are swept to zero
// with req.ready low; register writes are taken throughout.
module kmer_histogram_most_frequent import kmh_pkg::*; #(
  parameter int K_MAX      = K_MAX_DEFAULT,
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  kmh_req_if.sink                    req,
  kmh_res_if.source                  res,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output      logic [APB_DATA_W-1:0] prdata,
  output      logic                  pready
);

  logic [KLEN_W-1:0] kmer_length;
  kmh_cmd_t          cmd;
  kmh_stat_t         status;

  // Register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= KMER_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_KMER_LENGTH)) begin
      kmer_length <= pwdata[KLEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_KMER_LENGTH) ? APB_DATA_W'(kmer_length) : '0;

  kmh_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req.valid),
    .req_operation  (req.operation),
    .req_first_base (req.first_base),
    .req_ready      (req.ready),
    .status         (status),
    .cmd            (cmd)
  );

  kmh_dp #(
    .K_MAX      (K_MAX),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .kmer_length    (kmer_length),
    .req_base_code  (req.base_code),
    .req_last_base  (req.last_base),
    .out_ready      (res.ready),
    .out_valid      (res.valid),
    .out_kmer_code  (res.kmer_code),
    .out_kmer_count (res.kmer_count),
    .out_found      (res.found)
  );

endmodule

`default_nettype wire

/* rtl/kmh_ram.sv */
`default_nettype none

module kmh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/kmh_ctrl.sv */
`default_nettype none

module kmh_ctrl import kmh_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  input  wire logic      req_operation,
  input  wire logic      req_first_base,
  output      logic      req_ready,
  input  wire kmh_stat_t status,
  output      kmh_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_CLEAR  = 7'b0000100,
    ST_LOOKUP = 7'b0001000,
    ST_UPDATE = 7'b0010000,
    ST_SCAN   = 7'b0100000,
    ST_MISS   = 7'b1000000
  } kmh_state_t;

  kmh_state_t state;
  kmh_state_t state_next;
  logic       accept;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  // Sequence each request through its steps
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_INIT: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_operation == OP_FETCH) begin
            if (status.cursor_end) begin
              state_next = ST_MISS;
            end else begin
              cmd.fetch_start = 1'b1;
              state_next      = ST_SCAN;
            end
          end else if (req_first_base) begin
            cmd.clear_start = 1'b1;
            state_next      = ST_CLEAR;
          end else begin
            cmd.base_live = 1'b1;
            state_next    = ST_UPDATE;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.base_held = 1'b1;
        state_next    = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        // hold the probe while the output register is full
        if (status.out_free) begin
          cmd.scan_step = 1'b1;
          if (status.probe_hit || status.probe_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_MISS: begin
        if (status.out_free) begin
          cmd.emit_miss = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // A plain base is written back in the very next cycle
  a_base_update: assert property (@(posedge clk) disable iff (rst)
    (accept && req_operation == OP_BASE && !req_first_base) |=> cmd.update)
    else $error("base request not followed by counter write-back");

  // The sweep stops after its last entry
  a_sweep_stop: assert property (@(posedge clk) disable iff (rst)
    (cmd.clear_step && status.clear_last) |=> !cmd.clear_step)
    else $error("clear sweep ran past its last entry");

  // No request is taken while a sweep is running
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> !req_ready)
    else $error("request accepted during clear sweep");

endmodule

`default_nettype wire

/* rtl/kmh_dp.sv */
`default_nettype none

module kmh_dp import kmh_pkg::*; #(
  parameter int K_MAX      = K_MAX_DEFAULT,
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire kmh_cmd_t                cmd,
  output      kmh_stat_t               status,
  input  wire logic [KLEN_W-1:0]       kmer_length,
  input  wire logic [BASE_W-1:0]       req_base_code,
  input  wire logic                    req_last_base,
  input  wire logic                    out_ready,
  output      logic                    out_valid,
  output      logic [KMER_CODE_W-1:0]  out_kmer_code,
  output      logic [KMER_COUNT_W-1:0] out_kmer_count,
  output      logic                    out_found
);

  localparam int AW    = 2 * K_MAX;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = COUNT_BITS;
  localparam int SHW   = $clog2(AW + 1);

  // Architectural state
  logic [AW-1:0]     window;
  logic [SEEN_W-1:0] seen;
  logic [CW-1:0]     max_count;
  logic [AW:0]       cursor;

  // Work registers
  logic [AW-1:0]     clear_addr;
  logic [AW-1:0]     probe;
  logic              do_count;
  logic [BASE_W-1:0] held_base;
  logic              held_last;

  // Active length, window mask and table span
  logic [KLEN_W-1:0] k_eff;
  logic [SHW-1:0]    shamt;
  logic [AW-1:0]     mask;
  logic [AW:0]       span;

  logic              base_step;
  logic [BASE_W-1:0] step_base;
  logic              step_last;
  logic [AW-1:0]     window_next;
  logic [SEEN_W-1:0] seen_next;

  logic [CW-1:0]     rd_data;
  logic [CW-1:0]     count_inc;
  logic [AW:0]       probe_inc;
  logic              load_hit;
  logic              load_miss;
  logic              load_out;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CW-1:0]     ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;

  logic [31:0]       code_wide;
  logic [31:0]       count_wide;

  always_comb begin
    if (kmer_length == '0) begin
      k_eff = KLEN_W'(1);
    end else if (kmer_length > KLEN_W'(K_MAX)) begin
      k_eff = KLEN_W'(K_MAX);
    end else begin
      k_eff = kmer_length;
    end
  end

  assign shamt = SHW'({k_eff, 1'b0});
  assign mask  = {AW{1'b1}} >> (SHW'(AW) - shamt);
  assign span  = (AW + 1)'(1) << shamt;

  // Shift the new base into the window
  assign base_step   = cmd.base_live || cmd.base_held;
  assign step_base   = cmd.base_live ? req_base_code : held_base;
  assign step_last   = cmd.base_live ? req_last_base : held_last;
  assign window_next = ((window << 2) | AW'(step_base)) & mask;
  assign seen_next   = (seen < SEEN_MAX) ? seen + SEEN_W'(1) : seen;

  // Saturating increment of the counter read back
  assign count_inc = (rd_data == {CW{1'b1}}) ? rd_data : rd_data + CW'(1);

  // Scan decisions
  assign probe_inc = {1'b0, probe} + (AW + 1)'(1);
  assign load_hit  = cmd.scan_step && status.probe_hit;
  assign load_miss = (cmd.scan_step && !status.probe_hit && status.probe_last) || cmd.emit_miss;
  assign load_out  = load_hit || load_miss;

  assign status.out_free   = !out_valid || out_ready;
  assign status.cursor_end = (cursor >= span);
  assign status.probe_hit  = (rd_data == max_count);
  assign status.probe_last = (probe_inc >= span);
  assign status.clear_last = (clear_addr == {AW{1'b1}});

  // Counter memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = window;
    ram_wdata = count_inc;
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
      ram_wdata = '0;
    end else if (cmd.update && do_count) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = window_next;
    priority if (base_step) begin
      ram_re = 1'b1;
    end else if (cmd.fetch_start) begin
      ram_re    = 1'b1;
      ram_raddr = cursor[AW-1:0];
    end else if (cmd.scan_step && !status.probe_hit && !status.probe_last) begin
      ram_re    = 1'b1;
      ram_raddr = probe_inc[AW-1:0];
    end
  end

  kmh_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Window, bases seen and max count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_start) begin
      window    <= '0;
      seen      <= '0;
      max_count <= '0;
    end else begin
      if (base_step) begin
        window <= window_next;
        seen   <= seen_next;
      end
      if (cmd.update && do_count && (count_inc > max_count)) begin
        max_count <= count_inc;
      end
    end
  end

  // Fetch cursor
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_start) begin
      cursor <= '0;
    end else if (base_step && step_last) begin
      cursor <= '0;
    end else if (load_hit) begin
      cursor <= probe_inc;
    end else if (cmd.scan_step && status.probe_last) begin
      cursor <= span;
    end
  end

  // Clear sweep address
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_start) begin
      clear_addr <= '0;
    end else if (cmd.clear_step) begin
      clear_addr <= clear_addr + AW'(1);
    end
  end

  // Work registers without reset
  always_ff @(posedge clk) begin
    if (cmd.clear_start) begin
      held_base <= req_base_code;
      held_last <= req_last_base;
    end
    if (base_step) begin
      do_count <= (seen_next >= SEEN_W'(k_eff));
    end
    if (cmd.fetch_start) begin
      probe <= cursor[AW-1:0];
    end else if (cmd.scan_step && !status.probe_hit && !status.probe_last) begin
      probe <= probe_inc[AW-1:0];
    end
  end

  // Output register
  assign code_wide  = 32'(probe);
  assign count_wide = 32'(max_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hit) begin
      out_kmer_code  <= code_wide[KMER_CODE_W-1:0];
      out_kmer_count <= count_wide[KMER_COUNT_W-1:0];
      out_found      <= 1'b1;
    end else if (load_miss) begin
      out_kmer_code  <= '0;
      out_kmer_count <= '0;
      out_found      <= 1'b0;
    end
  end

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || out_ready))
    else $error("result overwritten while receiver stalls");

  // The max only grows between clears
  a_max_grows: assert property (@(posedge clk) disable iff (rst)
    !cmd.clear_start |=> (max_count >= $past(max_count)))
    else $error("max count fell without a clear");

  // Memory is never read and written at one address in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("counter read collides with write-back");

endmodule

`default_nettype wire
